### src/page_mapped_flash_translation_macros.svh
// Assertion helpers for the flash translation controller RTL.
`ifndef PAGE_MAPPED_FLASH_TRANSLATION_MACROS_SVH
`define PAGE_MAPPED_FLASH_TRANSLATION_MACROS_SVH
// Check a condition at every clock edge out of reset.
`define PMFT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// Check that a trigger is followed in the next cycle by a consequence.
`define PMFT_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);
`endif

### src/pmft_pkg.sv
package pmft_pkg;

  localparam int unsigned BLOCKS        = 256;
  localparam int unsigned PAGES         = 64;
  localparam int unsigned LOGICAL_PAGES = 8192;
  localparam int unsigned STREAMS       = 3;
  localparam int unsigned PHYS_PAGES    = BLOCKS * PAGES;

  localparam int unsigned BLK_W   = $clog2(BLOCKS);
  localparam int unsigned PG_W    = $clog2(PAGES);
  localparam int unsigned CNT_W   = PG_W + 1;
  localparam int unsigned LP_W    = $clog2(LOGICAL_PAGES);
  localparam int unsigned PP_W    = BLK_W + PG_W;
  localparam int unsigned STR_W   = 2;
  localparam int unsigned ERASE_W = 24;
  localparam int unsigned ORDER_W = 32;
  localparam int unsigned WC_W    = 32;

  localparam logic [ERASE_W-1:0] ERASE_MAX = '1;

  typedef enum logic [1:0] {
    MODE_READ    = 2'd0,
    MODE_WRITE   = 2'd1,
    MODE_ERASE   = 2'd2,
    MODE_MIGRATE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_UNMAPPED = 2'd1,
    STATUS_NO_FREE  = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_WP0,
    S_WP1,
    S_SRCH,
    S_INV,
    S_INV1,
    S_TGT,
    S_TGT1,
    S_E_SCAN,
    S_E_CHK,
    S_E_BLK,
    S_E_BLK1,
    S_M1,
    S_M_SCAN,
    S_M_CHK,
    S_M_DONE,
    S_DONE
  } state_e;

  typedef struct packed {
    mode_e             mode;
    logic [LP_W-1:0]   logical_page;
    logic [BLK_W-1:0]  block_number;
    logic [STR_W-1:0]  stream;
  } in_t;

  typedef struct packed {
    logic [PP_W-1:0]   physical_page;
    status_e           status;
    logic [BLK_W-1:0]  open_block;
    logic [CNT_W-1:0]  moved_pages;
    logic [WC_W-1:0]   write_count;
  } out_t;

  typedef struct packed {
    logic            valid;
    logic [PP_W-1:0] ppage;
  } l2p_ent_t;

  typedef struct packed {
    logic            valid;
    logic [LP_W-1:0] lpage;
  } p2l_ent_t;

  typedef struct packed {
    logic [ERASE_W-1:0] erase;
    logic [CNT_W-1:0]   inv;
    logic [CNT_W-1:0]   wp;
    logic               free;
    logic [ORDER_W-1:0] order;
  } blk_ent_t;

  typedef struct packed {
    logic             valid;
    logic [BLK_W-1:0] blk;
  } open_t;

  typedef struct packed {
    logic            we;
    logic [LP_W-1:0] waddr;
    l2p_ent_t        wdata;
    logic [LP_W-1:0] raddr;
  } l2p_req_t;

  typedef struct packed {
    logic            we;
    logic [PP_W-1:0] waddr;
    p2l_ent_t        wdata;
    logic [PP_W-1:0] raddr;
  } p2l_req_t;

  typedef struct packed {
    logic             we;
    logic [BLK_W-1:0] waddr;
    blk_ent_t         wdata;
    logic [BLK_W-1:0] raddr;
  } blk_req_t;

endpackage

### src/pmft_ram.sv
module pmft_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/pmft_ctrl.sv
`include "page_mapped_flash_translation_macros.svh"

module pmft_ctrl import pmft_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_t      in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_t     out_res_o,
  output l2p_req_t l2p_req_o,
  input  l2p_ent_t l2p_rdata_i,
  output p2l_req_t p2l_req_o,
  input  p2l_ent_t p2l_rdata_i,
  output blk_req_t blk_req_o,
  input  blk_ent_t blk_rdata_i
);

  state_e             state_q, state_d;
  logic [PP_W-1:0]    clr_q, clr_d;
  open_t              open_q [STREAMS];
  open_t              open_d [STREAMS];
  logic [ORDER_W-1:0] seq_q, seq_d;
  logic [WC_W-1:0]    tw_q, tw_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  mode_e              mode_q, mode_d;
  logic [BLK_W-1:0]   blk_q, blk_d;
  logic [STR_W-1:0]   s_q, s_d;
  logic [LP_W-1:0]    wlp_q, wlp_d;
  l2p_ent_t           old_q, old_d;
  logic [BLK_W-1:0]   tgt_q, tgt_d;
  logic [CNT_W-1:0]   i_q, i_d;
  logic [CNT_W-1:0]   lim_q, lim_d;
  logic [BLK_W:0]     sc_q, sc_d;
  logic [BLK_W-1:0]   best_q, best_d;
  blk_ent_t           best_ent_q, best_ent_d;
  logic               found_q, found_d;
  logic [PP_W-1:0]    phys_q, phys_d;
  status_e            status_q, status_d;
  logic [BLK_W-1:0]   obk_q, obk_d;
  logic [CNT_W-1:0]   moved_q, moved_d;

  logic               stream_ok;
  open_t              cur_open;
  logic               room;
  logic [BLK_W:0]     sc_m1;
  logic [BLK_W-1:0]   cand_idx;
  logic               cand_better;
  logic               srch_last;
  logic               found_nxt;
  logic [BLK_W-1:0]   best_nxt;
  blk_ent_t           best_ent_nxt;
  logic               out_free;
  logic [PP_W-1:0]    new_page;
  blk_ent_t           ent_w;

  assign stream_ok   = 32'(in_req_i.stream) < STREAMS;
  assign cur_open    = open_q[s_q];
  assign room        = cur_open.valid && (blk_rdata_i.wp < CNT_W'(PAGES));
  assign sc_m1       = sc_q - 1'b1;
  assign cand_idx    = sc_m1[BLK_W-1:0];
  assign srch_last   = (sc_q == (BLK_W + 1)'(BLOCKS));
  assign out_free    = !out_valid_q || !out_stall_i;
  assign new_page    = {tgt_q, blk_rdata_i.wp[PG_W-1:0]};

  // least erase count first, then earliest freed; strict compare keeps the lower index
  always_comb begin
    cand_better = 1'b0;
    if (sc_q != '0 && blk_rdata_i.free) begin
      cand_better = !found_q || (blk_rdata_i.erase < best_ent_q.erase) ||
                    ((blk_rdata_i.erase == best_ent_q.erase) &&
                     (blk_rdata_i.order < best_ent_q.order));
    end
    found_nxt    = found_q || cand_better;
    best_nxt     = cand_better ? cand_idx : best_q;
    best_ent_nxt = cand_better ? blk_rdata_i : best_ent_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == PP_W'(PHYS_PAGES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_req_i.mode)
            MODE_READ:    state_d = S_RD;
            MODE_WRITE:   state_d = stream_ok ? S_WP0 : S_DONE;
            MODE_ERASE:   state_d = S_E_SCAN;
            MODE_MIGRATE: state_d = stream_ok ? S_M1 : S_DONE;
            default:      state_d = S_IDLE;
          endcase
        end
      end
      S_RD:     state_d = S_DONE;
      S_WP0:    state_d = S_WP1;
      S_WP1:    state_d = room ? S_INV : S_SRCH;
      S_SRCH: begin
        if (srch_last) begin
          if (found_nxt)                 state_d = S_INV;
          else if (mode_q == MODE_WRITE) state_d = S_DONE;
          else                           state_d = S_M_DONE;
        end
      end
      S_INV:    state_d = old_q.valid ? S_INV1 : S_TGT;
      S_INV1:   state_d = S_TGT;
      S_TGT:    state_d = S_TGT1;
      S_TGT1:   state_d = (mode_q == MODE_WRITE) ? S_DONE : S_M_SCAN;
      S_E_SCAN: state_d = S_E_CHK;
      S_E_CHK:  state_d = (i_q == CNT_W'(PAGES - 1)) ? S_E_BLK : S_E_SCAN;
      S_E_BLK:  state_d = S_E_BLK1;
      S_E_BLK1: state_d = S_DONE;
      S_M1:     state_d = S_M_SCAN;
      S_M_SCAN: state_d = (i_q >= lim_q) ? S_M_DONE : S_M_CHK;
      S_M_CHK:  state_d = p2l_rdata_i.valid ? S_WP0 : S_M_SCAN;
      S_M_DONE: state_d = S_DONE;
      S_DONE:   state_d = out_free ? S_IDLE : S_DONE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    clr_d       = clr_q;
    open_d      = open_q;
    seq_d       = seq_q;
    tw_d        = tw_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mode_d      = mode_q;
    blk_d       = blk_q;
    s_d         = s_q;
    wlp_d       = wlp_q;
    old_d       = old_q;
    tgt_d       = tgt_q;
    i_d         = i_q;
    lim_d       = lim_q;
    sc_d        = sc_q;
    best_d      = best_q;
    best_ent_d  = best_ent_q;
    found_d     = found_q;
    phys_d      = phys_q;
    status_d    = status_q;
    obk_d       = obk_q;
    moved_d     = moved_q;
    ent_w       = blk_rdata_i;

    l2p_req_o       = '0;
    l2p_req_o.raddr = (state_q == S_IDLE) ? in_req_i.logical_page : wlp_q;
    p2l_req_o       = '0;
    p2l_req_o.raddr = {blk_q, i_q[PG_W-1:0]};
    blk_req_o       = '0;

    unique case (state_q)
      S_CLEAR: begin
        l2p_req_o.we    = clr_q < PP_W'(LOGICAL_PAGES);
        l2p_req_o.waddr = clr_q[LP_W-1:0];
        p2l_req_o.we    = 1'b1;
        p2l_req_o.waddr = clr_q;
        blk_req_o.we    = clr_q < PP_W'(BLOCKS);
        blk_req_o.waddr = clr_q[BLK_W-1:0];
        blk_req_o.wdata = '{erase: '0, inv: '0, wp: '0, free: 1'b1,
                            order: ORDER_W'(clr_q)};
        clr_d           = clr_q + 1'b1;
      end
      S_IDLE: begin
        blk_req_o.raddr = in_req_i.block_number;
        if (in_valid_i) begin
          mode_d   = in_req_i.mode;
          blk_d    = in_req_i.block_number;
          s_d      = in_req_i.stream;
          wlp_d    = in_req_i.logical_page;
          i_d      = '0;
          phys_d   = '0;
          obk_d    = '0;
          moved_d  = '0;
          status_d = STATUS_OK;
          if ((in_req_i.mode == MODE_WRITE || in_req_i.mode == MODE_MIGRATE) &&
              !stream_ok) begin
            status_d = STATUS_NO_FREE;
          end
        end
      end
      S_RD: begin
        if (l2p_rdata_i.valid) phys_d = l2p_rdata_i.ppage;
        else                   status_d = STATUS_UNMAPPED;
      end
      S_WP0: begin
        blk_req_o.raddr = cur_open.blk;
      end
      S_WP1: begin
        old_d   = l2p_rdata_i;
        tgt_d   = cur_open.blk;
        sc_d    = '0;
        found_d = 1'b0;
      end
      S_SRCH: begin
        blk_req_o.raddr = sc_q[BLK_W-1:0];
        sc_d            = sc_q + 1'b1;
        best_d          = best_nxt;
        best_ent_d      = best_ent_nxt;
        found_d         = found_nxt;
        if (srch_last) begin
          if (found_nxt) begin
            // open the chosen block for this stream
            ent_w           = best_ent_nxt;
            ent_w.free      = 1'b0;
            blk_req_o.we    = 1'b1;
            blk_req_o.waddr = best_nxt;
            blk_req_o.wdata = ent_w;
            open_d[s_q]     = '{valid: 1'b1, blk: best_nxt};
            tgt_d           = best_nxt;
          end else begin
            status_d = STATUS_NO_FREE;
          end
        end
      end
      S_INV: begin
        blk_req_o.raddr = old_q.ppage[PP_W-1:PG_W];
        if (old_q.valid) begin
          p2l_req_o.we    = 1'b1;
          p2l_req_o.waddr = old_q.ppage;
        end
      end
      S_INV1: begin
        if (blk_rdata_i.inv < CNT_W'(PAGES)) ent_w.inv = blk_rdata_i.inv + 1'b1;
        blk_req_o.we    = 1'b1;
        blk_req_o.waddr = old_q.ppage[PP_W-1:PG_W];
        blk_req_o.wdata = ent_w;
      end
      S_TGT: begin
        blk_req_o.raddr = tgt_q;
      end
      S_TGT1: begin
        ent_w.wp        = blk_rdata_i.wp + 1'b1;
        blk_req_o.we    = 1'b1;
        blk_req_o.waddr = tgt_q;
        blk_req_o.wdata = ent_w;
        l2p_req_o.we    = 1'b1;
        l2p_req_o.waddr = wlp_q;
        l2p_req_o.wdata = '{valid: 1'b1, ppage: new_page};
        p2l_req_o.we    = 1'b1;
        p2l_req_o.waddr = new_page;
        p2l_req_o.wdata = '{valid: 1'b1, lpage: wlp_q};
        tw_d            = tw_q + 1'b1;
        if (mode_q == MODE_WRITE) begin
          phys_d = new_page;
        end else begin
          moved_d = moved_q + 1'b1;
          i_d     = i_q + 1'b1;
        end
      end
      S_E_SCAN: begin
      end
      S_E_CHK: begin
        if (p2l_rdata_i.valid) begin
          l2p_req_o.we    = 1'b1;
          l2p_req_o.waddr = p2l_rdata_i.lpage;
          p2l_req_o.we    = 1'b1;
          p2l_req_o.waddr = {blk_q, i_q[PG_W-1:0]};
        end
        i_d = i_q + 1'b1;
      end
      S_E_BLK: begin
        blk_req_o.raddr = blk_q;
      end
      S_E_BLK1: begin
        ent_w.erase = (blk_rdata_i.erase != ERASE_MAX) ?
                      blk_rdata_i.erase + ERASE_W'(1) : blk_rdata_i.erase;
        ent_w.inv   = '0;
        ent_w.wp    = '0;
        ent_w.free  = 1'b1;
        ent_w.order = seq_q;
        blk_req_o.we    = 1'b1;
        blk_req_o.waddr = blk_q;
        blk_req_o.wdata = ent_w;
        seq_d           = seq_q + 1'b1;
        obk_d           = blk_q;
        for (int k = 0; k < STREAMS; k++) begin
          if (open_q[k].valid && open_q[k].blk == blk_q) open_d[k] = '0;
        end
      end
      S_M1: begin
        // pages at or above the fill point were unwritten when the migrate began
        lim_d = blk_rdata_i.wp;
      end
      S_M_SCAN: begin
      end
      S_M_CHK: begin
        if (p2l_rdata_i.valid) wlp_d = p2l_rdata_i.lpage;
        else                   i_d   = i_q + 1'b1;
      end
      S_M_DONE: begin
        obk_d = cur_open.valid ? cur_open.blk : '0;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{physical_page: phys_q, status: status_q, open_block: obk_q,
                    moved_pages: moved_q, write_count: tw_q};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      seq_q       <= ORDER_W'(BLOCKS);
      tw_q        <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < STREAMS; k++) open_q[k] <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      seq_q       <= seq_d;
      tw_q        <= tw_d;
      out_valid_q <= out_valid_d;
      open_q      <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    mode_q     <= mode_d;
    blk_q      <= blk_d;
    s_q        <= s_d;
    wlp_q      <= wlp_d;
    old_q      <= old_d;
    tgt_q      <= tgt_d;
    i_q        <= i_d;
    lim_q      <= lim_d;
    sc_q       <= sc_d;
    best_q     <= best_d;
    best_ent_q <= best_ent_d;
    found_q    <= found_d;
    phys_q     <= phys_d;
    status_q   <= status_d;
    obk_q      <= obk_d;
    moved_q    <= moved_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  `PMFT_ASSERT_NEXT(a_writes_only_on_commit, state_q != S_TGT1, $stable(tw_q),
                    "write counter moved outside a page commit")
  `PMFT_ASSERT(a_commit_has_room, state_q != S_TGT1 || blk_rdata_i.wp < CNT_W'(PAGES),
               "page committed to a full block")
  `PMFT_ASSERT(a_search_read_only, state_q != S_SRCH || srch_last || !blk_req_o.we,
               "block table written during free block search")
  `PMFT_ASSERT(a_moved_bounded, state_q != S_M_SCAN || moved_q <= i_q,
               "more pages moved than scanned")

endmodule

### src/page_mapped_flash_translation.sv
// Page-mapped flash translation with three write streams.
// Requests enter on in_valid_i / in_stall_o carrying in_data_i (mode, logical page,
// block, stream); one result per request leaves on out_valid_o / out_stall_i.
// A request is taken while in_valid_i is high and in_stall_o low; the block works
// on one request at a time and stalls the input until its result is registered.
// Work per request:
//   read looks up the map; write drops any older copy of the page and, when a fresh
//   block must be opened, walks the block table, one entry a cycle, picking least
//   erase count then oldest free;
//   erase unmaps every valid page of the block and frees it, erase count raised;
//   migrate moves each valid page below the fill point to the stream's open block.
// Each table memory has a single registered read port: a step of a request reads
// an entry and writes the update back in the cycle after.
// After reset the block sweeps both maps to unmapped and loads the block table,
// one entry a cycle, with the input stalled throughout.
// A result held by a stalled receiver stays in the output register; the next
// request is still taken and worked on, and waits only to deliver its result.
module page_mapped_flash_translation import pmft_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  l2p_req_t l2p_req;
  l2p_ent_t l2p_rdata;
  p2l_req_t p2l_req;
  p2l_ent_t p2l_rdata;
  blk_req_t blk_req;
  blk_ent_t blk_rdata;

  // sequencer: decode the request, walk the tables, hold the result
  pmft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_data_o),
    .l2p_req_o   (l2p_req),
    .l2p_rdata_i (l2p_rdata),
    .p2l_req_o   (p2l_req),
    .p2l_rdata_i (p2l_rdata),
    .blk_req_o   (blk_req),
    .blk_rdata_i (blk_rdata)
  );

  // logical to physical map, valid bit plus page
  pmft_ram #(
    .WIDTH ($bits(l2p_ent_t)),
    .DEPTH (LOGICAL_PAGES)
  ) u_l2p_ram (
    .clk_i   (clk_i),
    .we_i    (l2p_req.we),
    .waddr_i (l2p_req.waddr),
    .wdata_i (l2p_req.wdata),
    .raddr_i (l2p_req.raddr),
    .rdata_o (l2p_rdata)
  );

  // physical to logical map, valid bit plus logical page
  pmft_ram #(
    .WIDTH ($bits(p2l_ent_t)),
    .DEPTH (PHYS_PAGES)
  ) u_p2l_ram (
    .clk_i   (clk_i),
    .we_i    (p2l_req.we),
    .waddr_i (p2l_req.waddr),
    .wdata_i (p2l_req.wdata),
    .raddr_i (p2l_req.raddr),
    .rdata_o (p2l_rdata)
  );

  // per-block record: erase count, invalid count, fill point, free flag, free order
  pmft_ram #(
    .WIDTH ($bits(blk_ent_t)),
    .DEPTH (BLOCKS)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_req.we),
    .waddr_i (blk_req.waddr),
    .wdata_i (blk_req.wdata),
    .raddr_i (blk_req.raddr),
    .rdata_o (blk_rdata)
  );

endmodule
